FILE: sv/firq31_pkg.sv
// shared types and constants of the saturating q31 fir filter
// no dependencies; imported by the top level and the checker
`default_nettype none

package firq31_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int PROD_W        = 2 * SAMPLE_W;
  localparam int PRODUCT_SHIFT = 31;
  localparam int TERM_W        = PROD_W - PRODUCT_SHIFT;

  localparam logic [3:0] MAX_HEADROOM = 4'd8;
  localparam logic [4:0] HIGHEST_TAP_RST = 5'd31;

  // operation codes of an input transaction
  localparam logic [1:0] OP_FILTER = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_HIGHEST_TAP = 2'd0;
  localparam logic [1:0] CFG_HEADROOM    = 2'd1;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [4:0]                 coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: sv/firq31_chan_if.sv
// valid/ready channel carrying one payload of a configurable type
// depends on nothing; payload types come from firq31_pkg at instantiation
`default_nettype none

interface firq31_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: sv/fir_filter_q31_saturating_top.sv
// direct-form q31 fir filter with headroom shift and 32-bit saturation
// depends on firq31_pkg, firq31_chan_if and firq31_ram
//
// usage
//   in_i   : transactions with op, sample_in, coef_index, coef_value
//            filter (op 0) gives one result, coefficient write (op 1) and
//            history clear (op 2) give none, op 3 does nothing
//   out_o  : one saturated sample_out per filter transaction, in order
//   cfg_i  : register writes, index 0 highest_tap, index 1 headroom_shift
//            (write only while the block is idle), always ready
// timing
//   a filter transaction walks the active taps through one shared multiply
//   and accumulate, one tap per cycle, fed by the history and coefficient
//   memories (one read port each); the result becomes valid in the same
//   cycle in which in_i.ready returns
//   coefficient writes and clears can follow each other back to back
// reset
//   per-entry valid bits make both memories read as zero, no clearing pass
// stall
//   a held result sits in the output register; in_i stays ready for the next
//   transaction and a following filter result waits in its last step
`default_nettype none

module fir_filter_q31_saturating_top
  import firq31_pkg::*;
#(
  parameter int TAPS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  firq31_chan_if.sink   in_i,
  firq31_chan_if.source out_o,
  firq31_chan_if.sink   cfg_i
);

  localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W = TERM_W + TAP_W + 1;
  localparam logic [8:0] TAPS_EXT    = 9'(TAPS);
  localparam logic [8:0] LAST_TAP    = 9'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  // configuration registers
  logic [4:0] highest_tap_q;
  logic [3:0] headroom_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_tap_q <= HIGHEST_TAP_RST;
      headroom_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_HIGHEST_TAP: highest_tap_q <= cfg_i.payload.data[4:0];
        CFG_HEADROOM:    headroom_q    <= cfg_i.payload.data[3:0];
        default: ;
      endcase
    end
  end

  // effective order and shift, clamped to what the store supports
  logic [8:0]       ht_ext;
  logic [8:0]       last_ext;
  logic [TAP_W-1:0] last_eff;
  logic [3:0]       hs_eff;

  assign ht_ext   = {4'b0, highest_tap_q};
  assign last_ext = (ht_ext > LAST_TAP) ? LAST_TAP : ht_ext;
  assign last_eff = last_ext[TAP_W-1:0];
  assign hs_eff   = (headroom_q > MAX_HEADROOM) ? MAX_HEADROOM : headroom_q;

  // sequencer
  state_e state_q, state_d;
  logic   in_acc;
  logic   is_filter;
  logic   out_free;

  logic [TAP_W-1:0] idx_q;
  logic [3:0]       hs_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  // data stage tags, registered alongside the memory read data
  logic             d_vld_q;
  logic             d_first_q;
  logic [TAP_W-1:0] d_idx_q;
  logic             d_hv_q;
  logic             d_cv_q;

  // product and accumulate
  logic                     m_vld_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic out_vld_q;
  logic signed [SAMPLE_W-1:0] out_data_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_filter  = (in_i.payload.op == OP_FILTER);
  assign out_free   = !out_vld_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && is_filter) state_d = S_RUN;
      S_RUN:   if (idx_q == '0) state_d = S_DRAIN;
      S_DRAIN: if (!d_vld_q && !m_vld_q) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // per-entry valid bits stand for the all-zero reset of both stores
  logic [TAPS-1:0] hvalid_q;
  logic [TAPS-1:0] cvalid_q;

  // coefficient write decode
  logic [8:0]       ci_ext;
  logic             coef_we;
  logic [TAP_W-1:0] coef_waddr;

  assign ci_ext     = {4'b0, in_i.payload.coef_index};
  assign coef_we    = in_acc && (in_i.payload.op == OP_COEF) && (ci_ext < TAPS_EXT);
  assign coef_waddr = ci_ext[TAP_W-1:0];

  // tap walk runs from the highest active tap down to tap 0, so the entry
  // read at i-1 has not yet been overwritten by this pass
  logic [TAP_W-1:0] hist_raddr;
  logic             issue;

  assign issue      = (state_q == S_RUN);
  assign hist_raddr = idx_q - TAP_W'(1);

  always_ff @(posedge clk_i) begin
    if (in_acc && is_filter) begin
      idx_q    <= last_eff;
      hs_q     <= hs_eff;
      sample_q <= in_i.payload.sample_in;
    end else if (issue && idx_q != '0) begin
      idx_q <= idx_q - TAP_W'(1);
    end
    d_first_q <= (idx_q == '0);
    d_idx_q   <= idx_q;
    d_hv_q    <= hvalid_q[hist_raddr];
    d_cv_q    <= cvalid_q[idx_q];
  end

  // memories
  logic [SAMPLE_W-1:0] hist_rdata;
  logic [SAMPLE_W-1:0] coef_rdata;
  logic signed [SAMPLE_W-1:0] hist_val;
  logic signed [SAMPLE_W-1:0] coef_val;

  firq31_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (d_vld_q),
    .waddr_i (d_idx_q),
    .wdata_i (hist_val),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  firq31_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (in_i.payload.coef_value),
    .raddr_i (idx_q),
    .rdata_o (coef_rdata)
  );

  // shifted history value: the new sample at tap 0, entry i-1 at each tap i above
  assign hist_val = d_first_q ? sample_q : (d_hv_q ? hist_rdata : '0);
  assign coef_val = d_cv_q ? coef_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      cvalid_q <= '0;
      d_vld_q  <= 1'b0;
      m_vld_q  <= 1'b0;
    end else begin
      d_vld_q <= issue;
      m_vld_q <= d_vld_q;
      if (in_acc && in_i.payload.op == OP_CLEAR) begin
        hvalid_q <= '0;
      end else if (d_vld_q) begin
        hvalid_q[d_idx_q] <= 1'b1;
      end
      if (coef_we) begin
        cvalid_q[coef_waddr] <= 1'b1;
      end
    end
  end

  // floor of product / 2^31 is the top bits of the product
  logic signed [TERM_W-1:0] term;
  assign term = prod_q[PROD_W-1:PRODUCT_SHIFT];

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(hist_val) * PROD_W'(coef_val);
    if (in_acc && is_filter) begin
      acc_q <= '0;
    end else if (m_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
    end
  end

  // headroom shift and saturation
  logic signed [ACC_W-1:0]    acc_shr;
  logic signed [SAMPLE_W-1:0] sat_val;

  assign acc_shr = acc_q >>> hs_q;

  always_comb begin
    if (acc_shr > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_W-1:0];
    end else if (acc_shr < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat_val = acc_shr[SAMPLE_W-1:0];
    end
  end

  // output register
  logic out_load;
  assign out_load = (state_q == S_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= sat_val;
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.payload.sample_out = out_data_q;

endmodule

`default_nettype wire

FILE: sv/firq31_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module firq31_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/firq31_chk.sv
// port-level checker for the saturating q31 fir filter, bound to the top
// depends on firq31_pkg and fir_filter_q31_saturating_top
`default_nettype none

module firq31_chk
  import firq31_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic [1:0]          in_op_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [SAMPLE_W-1:0] out_data_i
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transaction");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  // a filter transaction occupies the tap walk, so input closes next cycle
  a_busy_after_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == OP_FILTER |=> !in_ready_i)
    else $error("input open during tap walk");

  // coefficient, clear and unused transactions produce no result
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i != OP_FILTER && !out_valid_i
    |=> !out_valid_i)
    else $error("result without filter transaction");

endmodule

bind fir_filter_q31_saturating_top firq31_chk u_firq31_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.payload.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.payload.sample_out)
);

`default_nettype wire
